// ----- sv/sdfp_pkg.sv -----
`default_nettype none

package sdfp_pkg;

    typedef enum logic [1:0] {
        MODE_U16  = 2'd0,
        MODE_U32  = 2'd1,
        MODE_U64  = 2'd2,
        MODE_FIX3 = 2'd3
    } mode_t;

    localparam int unsigned ACC_W  = 64;
    localparam int unsigned FRAC_W = 10;

    // largest accumulators that still take one more digit, and the U16 result bound
    localparam logic [ACC_W-1:0] LIM_U16_PRE = 64'd6553;
    localparam logic [16:0]      LIM_U16     = 17'h0FFFF;
    localparam logic [ACC_W-1:0] LIM_U32     = 64'd429496729;
    localparam logic [ACC_W-1:0] LIM_U64     = 64'd1844674407370955161;
    localparam logic [3:0]       MAX_LAST_DIGIT = 4'd5;

    localparam logic [9:0]       FIX_SCALE   = 10'd1000;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 10'd999;

    // decided field, handed from the parser to the output stage
    typedef struct packed {
        logic              ok;
        logic              fix3;
        logic              minus;
        logic [ACC_W-1:0]  acc;
        logic [FRAC_W-1:0] frac_pad;
    } sdfp_res_t;

endpackage

`default_nettype wire

// ----- sv/strict_decimal_field_parser_top.sv -----
`default_nettype none

// Strict ASCII decimal field parser. Characters enter on the s_ stream, one
// per request; s_tuser marks the first character of a field. Leading blanks
// are skipped, then digits are read as an unsigned 16, 32 or 64 bit value
// (overflow is an error) or, in mode 3, as a signed value in thousandths
// with up to three decimals. Trailing blanks and then NUL, comma, CR or LF
// close the field and produce one result on the m_ stream; anything else,
// or a field with no digit, gives an error result with zero magnitude.
// Later characters are dropped until the next start marker. The block takes
// one character every cycle while the m_ stream is not stalled: the parse
// state loop (one multiply-by-ten add and limit compare) closes with no
// register inside it, and a decided field passes from the input register to
// the parse and decision register and is scaled to thousandths in the
// output register. number_mode is written on the cfg_ channel, reset value
// 1 (unsigned 32 bit), and must only change while no character is in
// flight; an open field then carries on in the new mode.

module strict_decimal_field_parser_top
    import sdfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] character
    input  wire logic        s_tuser,   // [0] field_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [63:0] magnitude, [64] is_negative
    output logic             m_tuser,   // [0] valid_number
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data   // [1:0] number_mode
);

    mode_t             mode_reg;
    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_start_reg;
    logic              parse_ready;
    logic              res_valid;
    sdfp_res_t         res;
    logic              out_ready;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic              out_neg_reg;
    logic [ACC_W-1:0]  out_mag_reg;
    logic [41:0]       scaled;
    logic [ACC_W-1:0]  mag_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_U32;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    // input register
    assign s_tready = !in_valid_reg || parse_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    sdfp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid_reg),
        .in_ready    (parse_ready),
        .character   (in_char_reg),
        .field_start (in_start_reg),
        .mode        (mode_reg),
        .res_valid   (res_valid),
        .res_ready   (out_ready),
        .res         (res)
    );

    // output stage: in mode 3 integer part times 1000 plus padded decimals, else the integer as is; zero on error
    assign out_ready = !out_valid_reg || m_tready;

    always_comb begin
        scaled = 42'(res.acc[31:0]) * 42'(FIX_SCALE);
        if (!res.ok) begin
            mag_next = '0;
        end else if (res.fix3) begin
            mag_next = ACC_W'(scaled) + ACC_W'(res.frac_pad);
        end else begin
            mag_next = res.acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= res_valid;
        end
        if (out_ready && res_valid) begin
            out_ok_reg  <= res.ok;
            out_neg_reg <= res.ok && res.fix3 && res.minus;
            out_mag_reg <= mag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {7'b0, out_neg_reg, out_mag_reg};

    a_error_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[64:0] == '0)
        else $error("error result carries a value");

    a_empty_input_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_result_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && out_ready |=> out_valid_reg)
        else $error("decided field did not reach the output register");

endmodule

`default_nettype wire

// ----- sv/sdfp_parse.sv -----
`default_nettype none

module sdfp_parse
    import sdfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  character,
    input  wire logic        field_start,
    input  wire mode_t       mode,
    output logic             res_valid,
    input  wire logic        res_ready,
    output sdfp_res_t        res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_SIGN, PH_INT, PH_FRAC, PH_TRAIL, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        GO_ON, GO_OK, GO_FAIL
    } go_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              saw_reg, saw_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [1:0]        fcnt_reg, fcnt_next;
    logic              minus_reg, minus_next;
    logic              res_valid_reg, res_valid_next;
    sdfp_res_t         res_reg, res_next;

    phase_t            ph;
    logic [ACC_W-1:0]  acc;
    logic              saw;
    logic [FRAC_W-1:0] frac;
    logic [1:0]        fcnt;
    logic              minus;
    logic              step;
    logic              digit, blank, term;
    logic [3:0]        dval;
    logic [ACC_W-1:0]  a10;
    logic              int_fail;
    logic [13:0]       frac10;
    logic [13:0]       pad_wide;
    go_t               go;

    assign in_ready  = !res_valid_reg || res_ready;
    assign step      = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a start marker restarts the parse on this very character
    always_comb begin
        ph    = field_start ? PH_LEAD : phase_reg;
        acc   = field_start ? '0 : acc_reg;
        saw   = field_start ? 1'b0 : saw_reg;
        frac  = field_start ? '0 : frac_reg;
        fcnt  = field_start ? 2'd0 : fcnt_reg;
        minus = field_start ? 1'b0 : minus_reg;
    end

    always_comb begin
        digit = character inside {[CH_ZERO:CH_NINE]};
        blank = (character == CH_SPACE) || (character == CH_TAB);
        term  = (character == CH_NUL) || (character == CH_COMMA) ||
                (character == CH_CR) || (character == CH_LF);
        dval  = character[3:0];
        a10   = {acc[ACC_W-4:0], 3'b000} + {acc[ACC_W-2:0], 1'b0} + ACC_W'(dval);
        case (mode)
            MODE_U16:  int_fail = (acc > LIM_U16_PRE) || (a10[16:0] > LIM_U16);
            MODE_U32:  int_fail = (acc > LIM_U32) ||
                                  ((acc == LIM_U32) && (dval > MAX_LAST_DIGIT));
            MODE_U64:  int_fail = (acc > LIM_U64) ||
                                  ((acc == LIM_U64) && (dval > MAX_LAST_DIGIT));
            default:   int_fail = 1'b0;
        endcase
        frac10 = {4'b0, frac} * 14'd10 + 14'(dval);
        case (fcnt)
            2'd1:    pad_wide = {4'b0, frac} * 14'd100;
            2'd2:    pad_wide = {4'b0, frac} * 14'd10;
            default: pad_wide = {4'b0, frac};
        endcase
    end

    always_comb begin
        go         = GO_ON;
        phase_next = ph;
        acc_next   = acc;
        saw_next   = saw;
        frac_next  = frac;
        fcnt_next  = fcnt;
        minus_next = minus;

        case (ph)
            PH_LEAD, PH_SIGN, PH_INT: begin
                if (digit) begin
                    if (int_fail) begin
                        go = GO_FAIL;
                    end else begin
                        acc_next   = (mode == MODE_FIX3) ? {32'b0, a10[31:0]} : a10;
                        saw_next   = 1'b1;
                        phase_next = PH_INT;
                    end
                end else if (ph == PH_LEAD) begin
                    if (blank) begin
                    end else if (mode == MODE_FIX3 &&
                                 (character == CH_PLUS || character == CH_MINUS)) begin
                        minus_next = (character == CH_MINUS);
                        phase_next = PH_SIGN;
                    end else if (mode == MODE_FIX3 && character == CH_POINT) begin
                        phase_next = PH_FRAC;
                    end else begin
                        go = GO_FAIL;
                    end
                end else if (ph == PH_SIGN) begin
                    if (character == CH_POINT) begin
                        phase_next = PH_FRAC;
                    end else begin
                        go = GO_FAIL;
                    end
                end else begin
                    if (mode == MODE_FIX3 && character == CH_POINT) begin
                        phase_next = PH_FRAC;
                    end else if (blank) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        go = term ? GO_OK : GO_FAIL;
                    end
                end
            end
            PH_FRAC: begin
                if (digit) begin
                    if (fcnt == 2'd3) begin
                        go = GO_FAIL;
                    end else begin
                        frac_next = frac10[FRAC_W-1:0];
                        fcnt_next = fcnt + 2'd1;
                        saw_next  = 1'b1;
                    end
                end else if (!saw) begin
                    go = GO_FAIL;
                end else if (blank) begin
                    phase_next = PH_TRAIL;
                end else begin
                    go = term ? GO_OK : GO_FAIL;
                end
            end
            PH_TRAIL: begin
                if (!blank) begin
                    go = term ? GO_OK : GO_FAIL;
                end
            end
            default: begin
            end
        endcase

        if (go != GO_ON) begin
            phase_next = PH_DONE;
        end

        res_next.ok       = (go == GO_OK);
        res_next.fix3     = (mode == MODE_FIX3);
        res_next.minus    = minus;
        res_next.acc      = acc;
        res_next.frac_pad = pad_wide[FRAC_W-1:0];

        res_valid_next = res_valid_reg && !res_ready;
        if (step && go != GO_ON) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            saw_reg       <= 1'b0;
            frac_reg      <= '0;
            fcnt_reg      <= 2'd0;
            minus_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (step) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                saw_reg   <= saw_next;
                frac_reg  <= frac_next;
                fcnt_reg  <= fcnt_next;
                minus_reg <= minus_next;
            end
        end
        if (step && go != GO_ON) begin
            res_reg <= res_next;
        end
    end

    a_decided_goes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        step && go != GO_ON |=> phase_reg == PH_DONE)
        else $error("field decided but parser not in done phase");

    a_frac_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frac_reg <= FRAC_MAX)
        else $error("fraction accumulator beyond three decimals");

    a_no_frac_without_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg == 2'd0 |-> frac_reg == '0)
        else $error("fraction value without fraction digits");

    a_stalled_res_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(res_reg))
        else $error("pending result lost or changed while stalled");

endmodule

`default_nettype wire
